### rtl/core/lfp_pkg.sv
// Shared byte classes and token type for the length-prefixed frame parser.
package lfp_pkg;

   localparam int QUEUE_DEPTH = 2;

   typedef logic [2:0] byte_class_type;

   localparam byte_class_type CLS_OTHER = 3'd0;
   localparam byte_class_type CLS_OPEN  = 3'd1;
   localparam byte_class_type CLS_ZERO  = 3'd2;
   localparam byte_class_type CLS_ONE   = 3'd3;
   localparam byte_class_type CLS_CLOSE = 3'd4;

   localparam logic [7:0] CHAR_OPEN  = 8'h5B;
   localparam logic [7:0] CHAR_CLOSE = 8'h5D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_ONE   = 8'h31;

   typedef struct packed {
      byte_class_type cls;
      logic [7:0]     data;
   } token_type;

endpackage

### rtl/core/lfp_req_if.sv
// Input channel interface carrying received bytes.
interface lfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source(output valid, output rx_byte, input ready);
   modport sink(input valid, input rx_byte, output ready);
endinterface

### rtl/core/lfp_rsp_if.sv
// Result channel interface carrying payload bytes, frame flags and counters.
interface lfp_rsp_if #(
   parameter int COUNTER_WIDTH = 16
);
   logic                     valid;
   logic                     ready;
   logic [7:0]               payload_byte;
   logic                     payload_valid;
   logic                     payload_last;
   logic                     frame_good;
   logic                     frame_error;
   logic [COUNTER_WIDTH-1:0] good_frames;
   logic [COUNTER_WIDTH-1:0] bad_frames;

   modport source(output valid, output payload_byte, output payload_valid,
                  output payload_last, output frame_good, output frame_error,
                  output good_frames, output bad_frames, input ready);
   modport sink(input valid, input payload_byte, input payload_valid,
                input payload_last, input frame_good, input frame_error,
                input good_frames, input bad_frames, output ready);
endinterface

### rtl/core/lfp_front.sv
// Front stage: accepts received bytes and registers them with their class.
module lfp_front (
   input  logic               clock,
   input  logic               reset,
   lfp_req_if.sink            req_ch,
   output lfp_pkg::token_type tok,
   output logic               tok_valid,
   input  logic               tok_ready
);

   logic               valid_ff;
   logic               valid_in;
   lfp_pkg::token_type tok_ff;
   lfp_pkg::token_type tok_in;
   logic               accept;

   assign req_ch.ready = !valid_ff || tok_ready;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      tok_in.data = req_ch.rx_byte;
      if (req_ch.rx_byte == lfp_pkg::CHAR_OPEN) begin
         tok_in.cls = lfp_pkg::CLS_OPEN;
      end else if (req_ch.rx_byte == lfp_pkg::CHAR_CLOSE) begin
         tok_in.cls = lfp_pkg::CLS_CLOSE;
      end else if (req_ch.rx_byte == lfp_pkg::CHAR_ZERO) begin
         tok_in.cls = lfp_pkg::CLS_ZERO;
      end else if (req_ch.rx_byte == lfp_pkg::CHAR_ONE) begin
         tok_in.cls = lfp_pkg::CLS_ONE;
      end else begin
         tok_in.cls = lfp_pkg::CLS_OTHER;
      end
   end

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (tok_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tok_ff <= tok_in;
      end
   end

   assign tok       = tok_ff;
   assign tok_valid = valid_ff;

endmodule

### rtl/core/lfp_queue.sv
// Short token queue between the front and back stages.
module lfp_queue (
   input  logic               clock,
   input  logic               reset,
   input  lfp_pkg::token_type in_tok,
   input  logic               in_valid,
   output logic               in_ready,
   output lfp_pkg::token_type out_tok,
   output logic               out_valid,
   input  logic               out_ready
);

   localparam int PTR_WIDTH = (lfp_pkg::QUEUE_DEPTH > 1) ? $clog2(lfp_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(lfp_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] LAST_PTR = PTR_WIDTH'(lfp_pkg::QUEUE_DEPTH - 1);
   localparam logic [CNT_WIDTH-1:0] FULL_CNT = CNT_WIDTH'(lfp_pkg::QUEUE_DEPTH);

   lfp_pkg::token_type   entry_ff [lfp_pkg::QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0] wr_ff;
   logic [PTR_WIDTH-1:0] wr_in;
   logic [PTR_WIDTH-1:0] rd_ff;
   logic [PTR_WIDTH-1:0] rd_in;
   logic [CNT_WIDTH-1:0] count_ff;
   logic [CNT_WIDTH-1:0] count_in;
   logic                 push;
   logic                 pop;

   assign in_ready  = count_ff != FULL_CNT;
   assign out_valid = count_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_tok   = entry_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (push) begin
         wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + PTR_WIDTH'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + PTR_WIDTH'(1);
      end
      count_in = count_ff + CNT_WIDTH'(push) - CNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= in_tok;
      end
   end

endmodule

### rtl/core/lfp_back.sv
// Back stage: frame state machine, counters and the result register.
module lfp_back #(
   parameter int LENGTH_DIGITS = 10,
   parameter int COUNTER_WIDTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  lfp_pkg::token_type tok,
   input  logic               tok_valid,
   output logic               tok_ready,
   lfp_rsp_if.source          rsp_ch
);

   localparam int DC_WIDTH = $clog2(LENGTH_DIGITS + 1);
   localparam logic [DC_WIDTH-1:0] LAST_DIGIT = DC_WIDTH'(LENGTH_DIGITS - 1);

   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_LENGTH  = 2'd1;
   localparam logic [1:0] PH_PAYLOAD = 2'd2;
   localparam logic [1:0] PH_CLOSING = 2'd3;

   logic [1:0]               phase_ff;
   logic [1:0]               phase_in;
   logic [DC_WIDTH-1:0]      digit_ff;
   logic [DC_WIDTH-1:0]      digit_in;
   logic [LENGTH_DIGITS-1:0] remain_ff;
   logic [LENGTH_DIGITS-1:0] remain_in;
   logic [LENGTH_DIGITS:0]   shifted;
   logic [COUNTER_WIDTH-1:0] good_ff;
   logic [COUNTER_WIDTH-1:0] good_in;
   logic [COUNTER_WIDTH-1:0] bad_ff;
   logic [COUNTER_WIDTH-1:0] bad_in;
   logic                     out_valid_ff;
   logic                     out_valid_in;
   logic [7:0]               pbyte_ff;
   logic [7:0]               pbyte_in;
   logic                     pvalid_ff;
   logic                     pvalid_in;
   logic                     plast_ff;
   logic                     plast_in;
   logic                     fgood_ff;
   logic                     fgood_in;
   logic                     ferr_ff;
   logic                     ferr_in;
   logic                     load;

   assign tok_ready = !out_valid_ff || rsp_ch.ready;
   assign load      = tok_valid && tok_ready;
   assign shifted   = {remain_ff, tok.cls == lfp_pkg::CLS_ONE};

   always_comb begin
      phase_in  = phase_ff;
      digit_in  = digit_ff;
      remain_in = remain_ff;
      good_in   = good_ff;
      bad_in    = bad_ff;
      pbyte_in  = '0;
      pvalid_in = 1'b0;
      plast_in  = 1'b0;
      fgood_in  = 1'b0;
      ferr_in   = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (tok.cls == lfp_pkg::CLS_OPEN) begin
               phase_in  = PH_LENGTH;
               digit_in  = '0;
               remain_in = '0;
            end
         end
         PH_LENGTH: begin
            if (tok.cls != lfp_pkg::CLS_ZERO && tok.cls != lfp_pkg::CLS_ONE) begin
               ferr_in = 1'b1;
            end else begin
               remain_in = shifted[LENGTH_DIGITS-1:0];
               if (digit_ff == LAST_DIGIT) begin
                  digit_in = '0;
                  phase_in = PH_PAYLOAD;
               end else begin
                  digit_in = digit_ff + DC_WIDTH'(1);
               end
            end
         end
         PH_PAYLOAD: begin
            if (remain_ff == '0) begin
               ferr_in = 1'b1;
            end else begin
               pbyte_in  = tok.data;
               pvalid_in = 1'b1;
               remain_in = remain_ff - LENGTH_DIGITS'(1);
               if (remain_ff == LENGTH_DIGITS'(1)) begin
                  plast_in = 1'b1;
                  phase_in = PH_CLOSING;
               end
            end
         end
         PH_CLOSING: begin
            if (tok.cls != lfp_pkg::CLS_CLOSE) begin
               ferr_in = 1'b1;
            end else begin
               fgood_in  = 1'b1;
               good_in   = good_ff + COUNTER_WIDTH'(1);
               phase_in  = PH_IDLE;
               digit_in  = '0;
               remain_in = '0;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
      if (ferr_in) begin
         bad_in    = bad_ff + COUNTER_WIDTH'(1);
         phase_in  = PH_IDLE;
         digit_in  = '0;
         remain_in = '0;
      end
   end

   always_comb begin
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         digit_ff     <= '0;
         remain_ff    <= '0;
         good_ff      <= '0;
         bad_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (load) begin
            phase_ff  <= phase_in;
            digit_ff  <= digit_in;
            remain_ff <= remain_in;
            good_ff   <= good_in;
            bad_ff    <= bad_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pbyte_ff  <= pbyte_in;
         pvalid_ff <= pvalid_in;
         plast_ff  <= plast_in;
         fgood_ff  <= fgood_in;
         ferr_ff   <= ferr_in;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.payload_byte  = pbyte_ff;
   assign rsp_ch.payload_valid = pvalid_ff;
   assign rsp_ch.payload_last  = plast_ff;
   assign rsp_ch.frame_good    = fgood_ff;
   assign rsp_ch.frame_error   = ferr_ff;
   assign rsp_ch.good_frames   = good_ff;
   assign rsp_ch.bad_frames    = bad_ff;

   a_last_has_payload: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && plast_ff |-> pvalid_ff)
      else $error("payload_last set without payload_valid");

   a_one_outcome: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> $countones({pvalid_ff, fgood_ff, ferr_ff}) <= 1)
      else $error("more than one outcome flagged for one byte");

   a_good_count_step: assert property (@(posedge clock) disable iff (reset)
      load && fgood_in |=> good_ff == $past(good_ff) + COUNTER_WIDTH'(1))
      else $error("good frame counter did not advance with a good frame");

   a_bad_count_step: assert property (@(posedge clock) disable iff (reset)
      load && ferr_in |=> bad_ff == $past(bad_ff) + COUNTER_WIDTH'(1))
      else $error("bad frame counter did not advance with an aborted frame");

   a_closing_after_last: assert property (@(posedge clock) disable iff (reset)
      load && plast_in |=> phase_ff == PH_CLOSING)
      else $error("last payload byte did not lead to the closing phase");

endmodule

### rtl/core/length_prefixed_frame_parser.sv
// Top level of the length-prefixed frame parser: front, queue and back stages.
//
//   Channel  Dir  Handshake    Payload
//   req_ch   in   valid/ready  rx_byte[7:0]
//   rsp_ch   out  valid/ready  payload_byte, payload_valid, payload_last,
//                              frame_good, frame_error, good_frames, bad_frames
//
// Every accepted byte yields exactly one result; one byte per cycle is sustained while rsp_ch is ready.
// A req transfer passes to its result through the front register, the two-entry queue
// and the result register.
// Reset is synchronous and clears the frame state, both counters and the stage valids.
// A stalled rsp_ch holds the result register; the queue then fills and req_ch
// drops ready only when the front register and the queue are both occupied.
module length_prefixed_frame_parser #(
   parameter int LENGTH_DIGITS = 10,
   parameter int COUNTER_WIDTH = 16
) (
   input logic        clock,
   input logic        reset,
   lfp_req_if.sink    req_ch,
   lfp_rsp_if.source  rsp_ch
);

   lfp_pkg::token_type front_tok;
   logic               front_valid;
   logic               front_ready;
   lfp_pkg::token_type back_tok;
   logic               back_valid;
   logic               back_ready;

   lfp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .tok       (front_tok),
      .tok_valid (front_valid),
      .tok_ready (front_ready)
   );

   lfp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_tok    (front_tok),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .out_tok   (back_tok),
      .out_valid (back_valid),
      .out_ready (back_ready)
   );

   lfp_back #(
      .LENGTH_DIGITS (LENGTH_DIGITS),
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .tok       (back_tok),
      .tok_valid (back_valid),
      .tok_ready (back_ready),
      .rsp_ch    (rsp_ch)
   );

endmodule
